// File: hdl/bpa_pkg.sv
// bitmap page allocator shared package
// status codes, operation codes and sizing constants; no dependencies
package bpa_pkg;
	localparam int MAX_PAGES_DEF = 4096;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OOM = 2'd1;
	localparam logic [1:0] ST_FREE = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	typedef struct packed {
		logic start;
		logic is_free;
	} bpa_cmd_t;

	typedef struct packed {
		logic done;
		logic ready;
	} bpa_stat_t;
endpackage

// File: hdl/bpa_ctrl.sv
// bitmap page allocator controller
// handshake sequencing around the datapath; uses bpa_pkg
module bpa_ctrl
	import bpa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_op,
	output logic in_ready,
	input logic out_ready,
	output logic out_valid,
	output bpa_cmd_t cmd,
	input bpa_stat_t stat
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN = 2'd1;
	localparam logic [1:0] S_OUT = 2'd2;
	logic [1:0] state_q;

	assign in_ready = (state_q == S_IDLE) && stat.ready;
	assign out_valid = (state_q == S_OUT);
	assign cmd.start = in_valid && in_ready;
	assign cmd.is_free = in_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd.start) state_q <= S_RUN;
				S_RUN: if (stat.done) state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hdl/bpa_dp.sv
// bitmap page allocator datapath
// bitmap memory, scan and mark engine, counters; uses bpa_pkg
module bpa_dp
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input bpa_cmd_t cmd,
	output bpa_stat_t stat,
	input logic [12:0] cnt_in,
	input logic [11:0] idx_in,
	input logic [12:0] pool_cfg,
	output logic [1:0] status,
	output logic [11:0] index_res,
	output logic [12:0] used_res
);
	localparam int WORDS = (MAX_PAGES + 63) / 64;
	localparam int WA = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PW = $clog2(MAX_PAGES) + 2;
	localparam int CW = (PW > 14) ? PW : 14;

	localparam logic [3:0] D_IDLE = 4'd0;
	localparam logic [3:0] D_CLR = 4'd1;
	localparam logic [3:0] D_RD = 4'd2;
	localparam logic [3:0] D_EV = 4'd3;
	localparam logic [3:0] D_MRD = 4'd4;
	localparam logic [3:0] D_MWR = 4'd5;
	localparam logic [3:0] D_FRD = 4'd6;
	localparam logic [3:0] D_FWR = 4'd7;
	localparam logic [3:0] D_DONE = 4'd8;
	localparam logic [3:0] D_WAIT = 4'd9;

	logic [63:0] mem [WORDS];
	logic [63:0] rd_q;
	logic [WA-1:0] raddr, waddr;
	logic [63:0] wdata;
	logic we;

	logic [3:0] st_q;
	logic [WA:0] clr_q;
	logic [CW-1:0] i_q, k_q, run_q, size_q, cnt_q, end_q, used_q;
	logic [11:0] start_q;
	logic retry_q, range_q, twice_q;
	logic [1:0] status_q;
	logic [11:0] res_q;

	logic [CW-1:0] pool_ext, used_next;
	assign pool_ext = (CW'(pool_cfg) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(pool_cfg);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	logic [CW-1:0] pos;
	logic [5:0] bo;
	logic cur_bit;
	always_comb begin
		pos = (st_q == D_MRD || st_q == D_MWR) ? k_q :
			(st_q == D_FRD || st_q == D_FWR) ? k_q : i_q;
		bo = pos[5:0];
		cur_bit = rd_q[bo];
		raddr = WA'(pos >> 6);
		waddr = (st_q == D_CLR) ? WA'(clr_q) : WA'(pos >> 6);
		we = (st_q == D_CLR) || (st_q == D_MWR) ||
			(st_q == D_FWR && k_q < size_q && cur_bit);
		wdata = '0;
		if (st_q == D_MWR) wdata = rd_q | (64'd1 << bo);
		else if (st_q == D_FWR) wdata = rd_q & ~(64'd1 << bo);
	end

	assign stat.done = (st_q == D_DONE);
	assign stat.ready = (st_q != D_CLR);
	assign status = status_q;
	assign index_res = res_q;
	assign used_res = 13'(used_q);
	assign used_next = used_q + cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= D_CLR;
			clr_q <= '0;
			used_q <= '0;
			start_q <= '0;
			i_q <= '0; k_q <= '0; run_q <= '0; size_q <= '0; cnt_q <= '0;
			end_q <= '0;
			retry_q <= 1'b0; range_q <= 1'b0; twice_q <= 1'b0;
			status_q <= ST_OK; res_q <= '0;
		end else begin
			unique case (st_q)
				D_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (WA+1)'(WORDS - 1)) st_q <= D_IDLE;
				end
				D_IDLE: if (cmd.start) begin
					size_q <= pool_ext;
					cnt_q <= CW'(cnt_in);
					range_q <= 1'b0; twice_q <= 1'b0;
					res_q <= '0;
					status_q <= ST_OK;
					retry_q <= 1'b0;
					if (cmd.is_free) begin
						k_q <= CW'(idx_in);
						end_q <= CW'(idx_in) + CW'(cnt_in);
						st_q <= (cnt_in == '0) ? D_DONE : D_FRD;
					end else if (cnt_in == '0 || CW'(cnt_in) > pool_ext) begin
						status_q <= ST_RANGE;
						st_q <= D_DONE;
					end else if (((used_q >= pool_ext) ? CW'(0) : pool_ext - used_q)
							< CW'(cnt_in)) begin
						status_q <= ST_OOM;
						st_q <= D_DONE;
					end else begin
						i_q <= CW'(start_q);
						run_q <= '0;
						st_q <= D_RD;
					end
				end
				D_RD: begin
					if (i_q >= size_q) begin
						if (!retry_q) begin
							retry_q <= 1'b1;
							start_q <= '0;
							i_q <= '0;
							run_q <= '0;
						end else begin
							status_q <= ST_OOM;
							st_q <= D_DONE;
						end
					end else st_q <= D_EV;
				end
				D_EV: begin
					st_q <= D_RD;
					if (run_q == '0 && rd_q == '1) begin
						i_q <= (i_q | CW'(63)) + 1'b1;
					end else if (cur_bit) begin
						i_q <= i_q + 1'b1;
						run_q <= '0;
					end else if (run_q == '0 && cnt_q > size_q - i_q) begin
						i_q <= size_q;
					end else if (run_q + 1'b1 == cnt_q) begin
						k_q <= i_q - run_q;
						res_q <= 12'(i_q - run_q);
						start_q <= 12'(i_q - run_q);
						st_q <= D_MRD;
					end else begin
						run_q <= run_q + 1'b1;
						i_q <= i_q + 1'b1;
					end
				end
				D_MRD: st_q <= D_MWR;
				D_MWR: begin
					k_q <= k_q + 1'b1;
					if (k_q + 1'b1 == CW'(res_q) + cnt_q) begin
						used_q <= CW'(13'(used_next));
						st_q <= D_DONE;
					end else st_q <= D_MRD;
				end
				D_FRD: st_q <= D_FWR;
				D_FWR: begin
					if (k_q >= size_q) range_q <= 1'b1;
					else if (!cur_bit) twice_q <= 1'b1;
					else if (used_q != '0) used_q <= used_q - 1'b1;
					k_q <= k_q + 1'b1;
					if (k_q + 1'b1 == end_q) begin
						st_q <= D_WAIT;
					end else st_q <= D_FRD;
				end
				D_WAIT: begin
					status_q <= range_q ? ST_RANGE : (twice_q ? ST_FREE : ST_OK);
					st_q <= D_DONE;
				end
				D_DONE: st_q <= D_IDLE;
				default: st_q <= D_IDLE;
			endcase
		end
	end
endmodule

// File: hdl/bitmap_page_allocator.sv
// rejected requests and zero-page frees finish without touching the bitmap; allocate
// scans a page or a full word at a time (at most two passes), then marks each page;
// free reads and clears each page; one request at a time, the next one is
// taken only after the result word is accepted
// reset: asynchronous; after reset a clearing pass zeroes the bitmap before the
// first request is taken
module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int MAX_PAGES = MAX_PAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_ready,
	input logic operation,
	input logic [12:0] page_count,
	input logic [11:0] page_index,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic [11:0] page_index_out,
	output logic [12:0] used_count
);
	logic [12:0] pool_q;
	bpa_cmd_t cmd;
	bpa_stat_t stat;

	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {19'd0, pool_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pool_q <= 13'd4096;
		else if (psel && penable && pwrite && paddr == 1'b0) pool_q <= pwdata[12:0];
	end

	bpa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_op(operation), .in_ready(in_ready),
		.out_ready(out_ready), .out_valid(out_valid), .cmd(cmd), .stat(stat)
	);

	bpa_dp #(.MAX_PAGES(MAX_PAGES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cnt_in(page_count), .idx_in(page_index), .pool_cfg(pool_q),
		.status(status), .index_res(page_index_out), .used_res(used_count)
	);

	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_oob: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK && operation == OP_ALLOC |-> used_count != 13'd0 ||
		page_index_out == 12'd0) else $error("alloc ok with no used pages");
endmodule

// File: tb/bitmap_page_allocator_test.sv
// testbench for bitmap_page_allocator: directed and random allocate/free words
// checked against an in-bench next-fit bitmap predictor; depends on bpa_pkg
`timescale 1ns / 100ps
module bitmap_page_allocator_test
	import bpa_pkg::*;
();

	localparam int NPAGES = 4096;
	localparam int CYCLE_LIMIT = 200000000;

	typedef struct {
		logic op;
		logic [12:0] cnt;
		logic [11:0] idx;
		bit live;
	} req_t;

	typedef struct {
		logic [1:0] st;
		logic [11:0] at;
		logic [12:0] used;
	} resp_t;

	typedef struct {
		int first;
		int len;
	} run_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0, paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0, in_ready;
	logic operation = 0;
	logic [12:0] page_count = 0;
	logic [11:0] page_index = 0;
	logic out_valid, out_ready = 0;
	logic [1:0] status;
	logic [11:0] page_index_out;
	logic [12:0] used_count;

	req_t pending[$];
	resp_t expected[$];
	run_t live_runs[$];
	int issued = 0, accepted = 0;
	int in_gap = 0, out_gap = 0;
	bit calm = 0;
	int errors = 0;
	int cycles = 0;

	logic [63:0] pmap[64];
	int scan_from;
	int used_pages;
	int pool_reg;

	bitmap_page_allocator DUT (.*);

	always #4 clk = ~clk;

	function automatic bit page_taken(int p);
		return pmap[p >> 6][p & 63];
	endfunction

	function automatic bit find_run(int from, int size, int cnt, output int at);
		int i, k;
		i = from;
		at = 0;
		while (i < size) begin
			if (&pmap[(i >> 6) & 63]) begin
				i = (i | 63) + 1;
				continue;
			end
			if (page_taken(i)) begin
				i++;
				continue;
			end
			if (cnt > size - i) return 0;
			k = i;
			while (k < i + cnt && !page_taken(k)) k++;
			if (k == i + cnt) begin
				at = i;
				return 1;
			end
			i = k + 1;
		end
		return 0;
	endfunction

	function automatic resp_t allocate_or_free(logic op, int cnt, int idx);
		resp_t r;
		int size, avail, at, p;
		bit ok, range, twice;
		run_t rn;
		size = pool_reg > NPAGES ? NPAGES : pool_reg;
		r.st = ST_OK;
		r.at = 0;
		if (op == OP_ALLOC) begin
			avail = used_pages >= size ? 0 : size - used_pages;
			if (cnt == 0 || cnt > size) r.st = ST_RANGE;
			else if (avail < cnt) r.st = ST_OOM;
			else begin
				ok = find_run(scan_from, size, cnt, at);
				if (!ok) begin
					scan_from = 0;
					ok = find_run(0, size, cnt, at);
				end
				if (ok) begin
					for (int k = at; k < at + cnt; k++) pmap[k >> 6][k & 63] = 1'b1;
					scan_from = at & 12'hfff;
					used_pages = (used_pages + cnt) & 13'h1fff;
					r.at = 12'(at);
					rn.first = at;
					rn.len = cnt;
					live_runs.push_back(rn);
				end else r.st = ST_OOM;
			end
		end else begin
			range = 0;
			twice = 0;
			for (int k = 0; k < cnt; k++) begin
				p = idx + k;
				if (p >= size) range = 1;
				else if (!page_taken(p)) twice = 1;
				else begin
					pmap[p >> 6][p & 63] = 1'b0;
					if (used_pages > 0) used_pages--;
				end
			end
			r.st = range ? ST_RANGE : (twice ? ST_FREE : ST_OK);
		end
		r.used = 13'(used_pages);
		return r;
	endfunction

	// driver
	always @(negedge clk) begin
		req_t q;
		int j;
		if (arst_n && issued == accepted) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 0;
			end else if (pending.size() > 0) begin
				q = pending.pop_front();
				if (q.live && live_runs.size() > 0) begin
					j = $urandom_range(0, live_runs.size() - 1);
					q.idx = 12'(live_runs[j].first);
					q.cnt = 13'(live_runs[j].len);
					if ($urandom_range(0, 5) == 0) q.cnt = 13'($urandom_range(1, q.cnt));
					live_runs.delete(j);
				end
				in_valid <= 1;
				operation <= q.op;
				page_count <= q.cnt;
				page_index <= q.idx;
				issued <= issued + 1;
				if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 17);
			end else in_valid <= 0;
		end
	end

	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_ready <= 0;
		end else begin
			out_ready <= 1;
			if (!calm && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 17);
		end
	end

	// monitor
	always @(posedge clk) begin
		resp_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
		if (in_valid && in_ready) begin
			expected.push_back(allocate_or_free(operation, page_count, page_index));
			accepted <= accepted + 1;
		end
		if (out_valid && out_ready) begin
			if (expected.size() == 0) begin
				$display("%0t: unexpected word st=%0d at=%0d used=%0d", $time, status,
					page_index_out, used_count);
				errors++;
			end else begin
				e = expected.pop_front();
				if (status !== e.st || page_index_out !== e.at || used_count !== e.used) begin
					$display("%0t: expected st=%0d at=%0d used=%0d, got st=%0d at=%0d used=%0d",
						$time, e.st, e.at, e.used, status, page_index_out, used_count);
					errors++;
				end
			end
		end
	end

	task automatic push_req(logic op, int cnt, int idx, bit live = 0);
		req_t q;
		q.op = op;
		q.cnt = 13'(cnt);
		q.idx = 12'(idx);
		q.live = live;
		pending.push_back(q);
	endtask

	task automatic wait_drained();
		while (pending.size() > 0 || issued != accepted || expected.size() > 0 || in_valid)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_pool(int value);
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		paddr = 0;
		pwdata = value;
		@(negedge clk);
		penable = 1;
		@(posedge clk);
		pool_reg = value & 13'h1fff;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic random_burst(int n, int maxcnt);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 50) push_req(OP_ALLOC, $urandom_range(1, maxcnt), $urandom);
			else if (r < 85) push_req(OP_FREE, 0, 0, 1);
			else if (r < 95) push_req(OP_FREE, $urandom_range(0, 2 * maxcnt), $urandom);
			else push_req(1'($urandom), $urandom, $urandom);
		end
	endtask

	initial begin
		int pools[8] = '{100, 8191, 256, 0, 64, 4096, 1, 4096};
		foreach (pmap[i]) pmap[i] = '0;
		scan_from = 0;
		used_pages = 0;
		pool_reg = NPAGES;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		set_pool(4096);

		push_req(OP_ALLOC, 0, 0);
		push_req(OP_ALLOC, 8191, 4095);
		push_req(OP_ALLOC, 4096, 0);
		push_req(OP_ALLOC, 1, 0);
		push_req(OP_FREE, 1, 4095);
		push_req(OP_ALLOC, 1, 0);
		push_req(OP_FREE, 200, 4000);
		push_req(OP_FREE, 4096, 0);
		push_req(OP_FREE, 1, 0);
		push_req(OP_FREE, 0, 5);
		push_req(OP_ALLOC, 64, 0);
		push_req(OP_ALLOC, 3, 0);
		push_req(OP_FREE, 64, 0);
		push_req(OP_ALLOC, 70, 0);
		push_req(OP_ALLOC, 4000, 0);
		push_req(OP_ALLOC, 10, 0);
		push_req(OP_FREE, 8191, 4095);
		push_req(OP_ALLOC, 4096, 0);
		push_req(OP_FREE, 4096, 0);
		push_req(OP_ALLOC, 5, 4095);
		wait_drained();

		random_burst(300, 16);
		wait_drained();
		foreach (pools[p]) begin
			set_pool(pools[p]);
			if (p == 7) calm = 1;
			random_burst(200, (pools[p] >= 256) ? 48 : 8);
			if (p == 2) begin
				wait_drained();
				random_burst(50, 8);
			end
			wait_drained();
		end

		repeat (64) @(posedge clk);
		if (errors == 0 && expected.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
